[rtl/olte_pkg.sv]
package olte_pkg;

    // store geometry
    localparam int DEPTH  = 64;
    localparam int WORD_W = 32;
    localparam int CELL_W = $clog2(DEPTH);
    localparam int CNT_W  = 7;
    localparam int POS_W  = 8;
    localparam int KIND_W = 4;

    // reduction tree: cells are gathered in groups of eight
    localparam int GRP_N  = 8;
    localparam int GRP_IW = $clog2(GRP_N);
    localparam int NGRP   = DEPTH / GRP_N;
    localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(DEPTH);

    typedef enum logic [KIND_W-1:0] {
        K_INS_FRONT = 4'd0,
        K_REM_FRONT = 4'd1,
        K_INS_BACK  = 4'd2,
        K_REM_BACK  = 4'd3,
        K_INS_AT    = 4'd4,
        K_REM_AT    = 4'd5,
        K_SEARCH    = 4'd6,
        K_SELECT    = 4'd7,
        K_REPLACE   = 4'd8
    } t_kind;

    // per-cell operation broadcast along the chain
    typedef enum logic [2:0] {
        CO_HOLD,
        CO_INS,
        CO_REM,
        CO_PUT,
        CO_FLAG
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic [CELL_W-1:0]         pos;
        logic [CELL_W-1:0]         sel;
        logic [CNT_W-1:0]          count;
        logic signed [WORD_W-1:0]  word;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic                      full;
        logic                      empty;
        logic [CNT_W-1:0]          count;
        logic [CNT_W-1:0]          found;
        logic signed [WORD_W-1:0]  rd;
        logic                      ok;
    } t_result;

endpackage

[rtl/ordered_list_table_engine.sv]
// Edit operations (insert, remove, replace) finish in the accepting cycle; the result
// is registered and shown in the next cycle; a new item is taken every cycle while the
// output is not stalled and no search or select is busy. Search and select pass through
// flag capture in the cells, a registered group reduction, then the final combine;
// one such item is in flight at a time. Reset (synchronous, active low) empties the list
// and sets the capacity to 64; stored words are not cleared and need no clearing pass.
module ordered_list_table_engine
    import olte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // capacity register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // position[7:0], value[39:8]
    input  logic [3:0]  i_s_axis_tuser,   // kind[3:0]
    // results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata    // ok[0], read_value[32:1], found_position[39:33],
                                          // item_count[46:40], is_empty[47], is_full[48]
);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_cap;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_is_sel;
    logic                     r_ovalid;
    t_result                  r_out;

    t_cell_ctl                ctl;
    logic                     acc;
    logic                     multi;
    logic                     op_ok;
    logic [CNT_W-1:0]         eff_cap;
    logic [CNT_W-1:0]         cnt_m1;
    logic                     full_now;
    logic [POS_W-1:0]         tgt;
    t_kind                    kind;
    logic [POS_W-1:0]         pos_in;
    logic signed [WORD_W-1:0] word_in;

    logic [DEPTH-1:0][WORD_W-1:0] cell_data;
    logic [DEPTH-1:0]             cell_match;
    logic [DEPTH-1:0]             cell_hit;
    logic [NGRP-1:0]              g_any;
    logic [NGRP-1:0][GRP_IW-1:0]  g_first;
    logic [NGRP-1:0][WORD_W-1:0]  g_data;

    logic [CNT_W-1:0]  fin_found;
    logic [WORD_W-1:0] fin_data;
    logic              fin_any;

    assign kind    = t_kind'(i_s_axis_tuser);
    assign pos_in  = i_s_axis_tdata[POS_W-1:0];
    assign word_in = i_s_axis_tdata[POS_W +: WORD_W];
    assign acc     = i_s_axis_tvalid && o_s_axis_tready;

    assign eff_cap  = (r_cap > CAP_MAX) ? CAP_MAX : r_cap;
    assign cnt_m1   = r_count - 1'b1;
    assign full_now = r_count >= eff_cap;

    assign o_cfg_ready = 1'b1;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // decode of the incoming item into a chain command
    always_comb begin
        ctl.op    = CO_HOLD;
        ctl.pos   = '0;
        ctl.sel   = ({1'b0, pos_in} >= {2'b0, r_count}) ? cnt_m1[CELL_W-1:0]
                                                        : pos_in[CELL_W-1:0];
        ctl.count = r_count;
        ctl.word  = word_in;
        op_ok     = 1'b0;
        multi     = 1'b0;
        n_count   = r_count;
        tgt       = '0;
        unique case (kind)
            K_INS_FRONT, K_INS_BACK, K_INS_AT: begin
                tgt   = (kind == K_INS_FRONT) ? '0 :
                        (kind == K_INS_BACK)  ? {1'b0, r_count} : pos_in;
                op_ok = !full_now && (tgt <= {1'b0, r_count});
                if (op_ok) begin
                    ctl.op  = CO_INS;
                    n_count = r_count + 1'b1;
                end
            end
            K_REM_FRONT, K_REM_BACK, K_REM_AT: begin
                tgt   = (kind == K_REM_FRONT) ? '0 :
                        (kind == K_REM_BACK)  ? {1'b0, cnt_m1} : pos_in;
                op_ok = (r_count != '0) && (tgt < {1'b0, r_count});
                if (op_ok) begin
                    ctl.op  = CO_REM;
                    n_count = cnt_m1;
                end
            end
            K_REPLACE: begin
                tgt   = pos_in;
                op_ok = tgt < {1'b0, r_count};
                if (op_ok) begin
                    ctl.op = CO_PUT;
                end
            end
            K_SEARCH, K_SELECT: begin
                multi  = 1'b1;
                ctl.op = CO_FLAG;
            end
            default: ;
        endcase
        ctl.pos = tgt[CELL_W-1:0];
        if (!acc) begin
            ctl.op = CO_HOLD;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (acc && multi) n_state = ST_GROUP;
            ST_GROUP: n_state = ST_FINAL;
            ST_FINAL: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_s_axis_tready = !r_ovalid || i_m_axis_tready;
            ST_GROUP: o_s_axis_tready = 1'b0;
            ST_FINAL: o_s_axis_tready = 1'b0;
            default:  o_s_axis_tready = 1'b0;
        endcase
    end

    // cell chain
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic signed [WORD_W-1:0] left_w, right_w;
        assign left_w  = (gi == 0) ? '0 : cell_data[(gi == 0) ? 0 : gi - 1];
        assign right_w = (gi == DEPTH - 1) ? '0 : cell_data[(gi == DEPTH - 1) ? gi : gi + 1];
        olte_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (CELL_W'(gi)),
            .i_ctl   (ctl),
            .i_left  (left_w),
            .i_right (right_w),
            .o_data  (cell_data[gi]),
            .o_match (cell_match[gi]),
            .o_hit   (cell_hit[gi])
        );
    end

    // group reduction
    for (genvar gg = 0; gg < NGRP; gg++) begin : g_grp
        olte_group u_grp (
            .i_clk   (i_clk),
            .i_data  (cell_data[gg*GRP_N +: GRP_N]),
            .i_match (cell_match[gg*GRP_N +: GRP_N]),
            .i_hit   (cell_hit[gg*GRP_N +: GRP_N]),
            .o_any   (g_any[gg]),
            .o_first (g_first[gg]),
            .o_data  (g_data[gg])
        );
    end

    // final combine over the groups
    always_comb begin
        fin_any   = |g_any;
        fin_found = r_count;
        fin_data  = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (g_any[g]) begin
                fin_found = CNT_W'({NGRP_W'(g), g_first[g]});
            end
        end
        for (int g = 0; g < NGRP; g++) begin
            fin_data = fin_data | g_data[g];
        end
        if (!fin_any) begin
            fin_found = r_count;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc) begin
                r_count <= n_count;
            end
            if (acc && !multi) begin
                r_ovalid <= 1'b1;
            end else if (r_state == ST_FINAL) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_is_sel <= (kind == K_SELECT);
        end
        if (acc && !multi) begin
            r_out.ok    <= op_ok;
            r_out.rd    <= '0;
            r_out.found <= '0;
            r_out.count <= n_count;
            r_out.empty <= (n_count == '0);
            r_out.full  <= (n_count >= eff_cap);
        end else if (r_state == ST_FINAL) begin
            r_out.ok    <= 1'b0;
            r_out.rd    <= !r_is_sel ? '0 : (r_count == '0) ? '1 : fin_data;
            r_out.found <= r_is_sel ? '0 : fin_found;
            r_out.count <= r_count;
            r_out.empty <= (r_count == '0);
            r_out.full  <= full_now;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {7'b0, r_out};

endmodule

[rtl/olte_cell.sv]
module olte_cell
    import olte_pkg::*;
(
    input  logic                     i_clk,
    input  logic [CELL_W-1:0]        i_idx,
    input  t_cell_ctl                i_ctl,
    input  logic signed [WORD_W-1:0] i_left,
    input  logic signed [WORD_W-1:0] i_right,
    output logic signed [WORD_W-1:0] o_data,
    output logic                     o_match,
    output logic                     o_hit
);

    logic signed [WORD_W-1:0] r_data, n_data;
    logic                     r_match, n_match;
    logic                     r_hit, n_hit;

    // entry update: shift up on insert, down on remove, direct write
    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CO_INS: begin
                if (i_idx > i_ctl.pos) begin
                    n_data = i_left;
                end else if (i_idx == i_ctl.pos) begin
                    n_data = i_ctl.word;
                end
            end
            CO_REM: begin
                if (i_idx >= i_ctl.pos) begin
                    n_data = i_right;
                end
            end
            CO_PUT: begin
                if (i_idx == i_ctl.pos) begin
                    n_data = i_ctl.word;
                end
            end
            default: ;
        endcase
    end

    // search and select flags, captured on the accepting cycle
    always_comb begin
        n_match = r_match;
        n_hit   = r_hit;
        if (i_ctl.op == CO_FLAG) begin
            n_match = (r_data == i_ctl.word) && ({1'b0, i_idx} < i_ctl.count);
            n_hit   = (i_idx == i_ctl.sel);
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
        r_hit   <= n_hit;
    end

    assign o_data  = r_data;
    assign o_match = r_match;
    assign o_hit   = r_hit;

endmodule

[rtl/olte_group.sv]
module olte_group
    import olte_pkg::*;
(
    input  logic                                i_clk,
    input  logic [GRP_N-1:0][WORD_W-1:0]        i_data,
    input  logic [GRP_N-1:0]                    i_match,
    input  logic [GRP_N-1:0]                    i_hit,
    output logic                                o_any,
    output logic [GRP_IW-1:0]                   o_first,
    output logic [WORD_W-1:0]                   o_data
);

    logic                r_any, n_any;
    logic [GRP_IW-1:0]   r_first, n_first;
    logic [WORD_W-1:0]   r_data, n_data;

    // first match within the group and the selected word
    always_comb begin
        n_any   = |i_match;
        n_first = '0;
        n_data  = '0;
        for (int k = GRP_N - 1; k >= 0; k--) begin
            if (i_match[k]) begin
                n_first = GRP_IW'(k);
            end
        end
        for (int k = 0; k < GRP_N; k++) begin
            n_data = n_data | (i_hit[k] ? i_data[k] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_any   <= n_any;
        r_first <= n_first;
        r_data  <= n_data;
    end

    assign o_any   = r_any;
    assign o_first = r_first;
    assign o_data  = r_data;

endmodule
